FILE: rtl/bba_pkg.sv
// Shared constants, types and helpers for the buddy block allocator.
`timescale 1ns / 1ps
package bba_pkg;

  // Pool geometry: usable pool is the largest power of two within POOL_UNITS
  localparam int POOL_UNITS = 1024;
  localparam int POOL_ORDER = $clog2(POOL_UNITS + 1) - 1;
  localparam int POOL_SIZE  = 1 << POOL_ORDER;

  // Field and index widths
  localparam int ADDR_W = 10;
  localparam int SIZE_W = 11;
  localparam int IDX_W  = ADDR_W + 1;
  localparam int ORD_W  = 4;

  // Command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // One block table entry: block start flag, in-use flag, size order
  typedef struct packed {
    logic             start;
    logic             used;
    logic [ORD_W-1:0] order;
  } blk_entry_t;

  localparam int ENTRY_W = $bits(blk_entry_t);

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SPLIT,
    ST_FCHK,
    ST_FBUD,
    ST_FLOW,
    ST_DONE
  } bba_state_t;

  // Order of the power of two that holds size units (zero counts as one)
  function automatic logic [ORD_W-1:0] size_order(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] m;
    logic [ORD_W-1:0]  k;
    m = (size == '0) ? '0 : size - SIZE_W'(1);
    k = '0;
    for (int j = 0; j < SIZE_W; j++) begin
      if (m[j]) begin
        k = ORD_W'(j + 1);
      end
    end
    return k;
  endfunction

endpackage

FILE: rtl/bba_in_if.sv
// Request channel: valid/ready handshake with command and operands.
`timescale 1ns / 1ps
interface bba_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [bba_pkg::SIZE_W-1:0]  request_size;
  logic [bba_pkg::ADDR_W-1:0]  free_address;

  modport source (output valid, cmd, request_size, free_address, input ready);
  modport sink   (input valid, cmd, request_size, free_address, output ready);
endinterface

FILE: rtl/bba_out_if.sv
// Result channel: valid/ready handshake with status and block bounds.
`timescale 1ns / 1ps
interface bba_out_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [bba_pkg::ADDR_W-1:0]  first_unit;
  logic [bba_pkg::ADDR_W-1:0]  last_unit;

  modport source (output valid, ok, first_unit, last_unit, input ready);
  modport sink   (input valid, ok, first_unit, last_unit, output ready);
endinterface

FILE: rtl/bba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, old data on a same-cycle collision
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/buddy_block_allocator.sv
// Top level of the binary buddy allocator: sequencer around the block table RAM.
//
//   channel   dir   handshake      word
//   in_chan   in    valid/ready    cmd, request_size, free_address
//   out_chan  out   valid/ready    ok, first_unit, last_unit
//
// After reset a clearing pass writes all 1024 table entries, one a cycle,
// before the first request is taken.
// Allocate: a table walk over the blocks (up to 1024 visited), one step per
// split, then the result. Free: a check, then a buddy read and a merge per merge step.
// The single table read port sets the walk rate; one request is in work at a time.
// A result waits in the output register; the next request is taken meanwhile.
`timescale 1ns / 1ps
module buddy_block_allocator (
  input logic        clk,
  input logic        rst_n,
  bba_in_if.sink     in_chan,
  bba_out_if.source  out_chan
);

  bba_pkg::bba_state_t state_r, state_nxt;

  logic [bba_pkg::ADDR_W-1:0]  clr_idx_r, clr_idx_nxt;
  logic [bba_pkg::IDX_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic [bba_pkg::ORD_W-1:0]   k_r, k_nxt;
  logic                        found_r, found_nxt;
  logic [bba_pkg::ADDR_W-1:0]  best_r, best_nxt;
  logic [bba_pkg::ORD_W-1:0]   best_ord_r, best_ord_nxt;
  logic [bba_pkg::ADDR_W-1:0]  cur_a_r, cur_a_nxt;
  logic [bba_pkg::ORD_W-1:0]   cur_ord_r, cur_ord_nxt;
  logic                        res_ok_r, res_ok_nxt;
  logic [bba_pkg::ADDR_W-1:0]  res_start_r, res_start_nxt;
  logic [bba_pkg::ADDR_W-1:0]  res_end_r, res_end_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_ok_r;
  logic [bba_pkg::ADDR_W-1:0]  out_start_r;
  logic [bba_pkg::ADDR_W-1:0]  out_end_r;

  logic                          ram_we;
  logic [bba_pkg::ADDR_W-1:0]    ram_waddr;
  bba_pkg::blk_entry_t           ram_wentry;
  logic [bba_pkg::ADDR_W-1:0]    ram_raddr;
  logic [bba_pkg::ENTRY_W-1:0]   ram_rdata;
  bba_pkg::blk_entry_t           rd_entry;

  logic                          in_accept;
  logic [bba_pkg::ORD_W-1:0]     in_k;
  logic [bba_pkg::IDX_W-1:0]     scan_step;
  logic [bba_pkg::IDX_W-1:0]     scan_nxt;
  logic                          scan_end;
  logic                          scan_hit;
  logic                          split_more;
  logic [bba_pkg::ORD_W-1:0]     split_ord;
  logic                          free_ok;
  logic [bba_pkg::ADDR_W-1:0]    cur_mask;
  logic                          buddy_ok;
  logic [bba_pkg::ADDR_W-1:0]    low_addr;
  logic [bba_pkg::ADDR_W-1:0]    high_addr;
  logic [bba_pkg::ORD_W-1:0]     ord_up;
  logic                          out_free;

  // Block table
  bba_ram #(
    .WIDTH (bba_pkg::ENTRY_W),
    .DEPTH (bba_pkg::POOL_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_entry = bba_pkg::blk_entry_t'(ram_rdata);

  // Handshake and shared decode
  assign in_chan.ready = (state_r == bba_pkg::ST_IDLE);
  assign in_accept     = in_chan.valid & in_chan.ready;
  assign in_k          = bba_pkg::size_order(in_chan.request_size);
  assign out_free      = ~out_valid_r | out_chan.ready;

  // Table walk: step over whole blocks, single units elsewhere
  assign scan_step = rd_entry.start ? (bba_pkg::IDX_W'(1) << rd_entry.order)
                                    : bba_pkg::IDX_W'(1);
  assign scan_nxt  = scan_idx_r + scan_step;
  assign scan_end  = scan_nxt[bba_pkg::IDX_W-1];
  assign scan_hit  = rd_entry.start & ~rd_entry.used & (rd_entry.order >= k_r) &
                     (~found_r | (rd_entry.order < best_ord_r));

  // Split down to the requested order
  assign split_more = (best_ord_r > k_r);
  assign split_ord  = best_ord_r - bba_pkg::ORD_W'(1);

  // Free and buddy merge
  assign free_ok   = rd_entry.start & rd_entry.used;
  assign cur_mask  = bba_pkg::ADDR_W'(1) << cur_ord_r;
  assign buddy_ok  = rd_entry.start & ~rd_entry.used & (rd_entry.order == cur_ord_r);
  assign low_addr  = cur_a_r & ~cur_mask;
  assign high_addr = cur_a_r | cur_mask;
  assign ord_up    = cur_ord_r + bba_pkg::ORD_W'(1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bba_pkg::ST_CLEAR: begin
        if (clr_idx_r == bba_pkg::ADDR_W'(bba_pkg::POOL_SIZE - 1)) begin
          state_nxt = bba_pkg::ST_IDLE;
        end
      end
      bba_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (in_chan.cmd == bba_pkg::CMD_FREE) begin
            state_nxt = bba_pkg::ST_FCHK;
          end else if (in_k > bba_pkg::ORD_W'(bba_pkg::POOL_ORDER)) begin
            state_nxt = bba_pkg::ST_DONE;
          end else begin
            state_nxt = bba_pkg::ST_SCAN;
          end
        end
      end
      bba_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_nxt = (found_r | scan_hit) ? bba_pkg::ST_SPLIT : bba_pkg::ST_DONE;
        end
      end
      bba_pkg::ST_SPLIT: begin
        if (!split_more) begin
          state_nxt = bba_pkg::ST_DONE;
        end
      end
      bba_pkg::ST_FCHK: begin
        if (!free_ok || rd_entry.order >= bba_pkg::ORD_W'(bba_pkg::POOL_ORDER)) begin
          state_nxt = bba_pkg::ST_DONE;
        end else begin
          state_nxt = bba_pkg::ST_FBUD;
        end
      end
      bba_pkg::ST_FBUD: begin
        state_nxt = buddy_ok ? bba_pkg::ST_FLOW : bba_pkg::ST_DONE;
      end
      bba_pkg::ST_FLOW: begin
        state_nxt = (ord_up >= bba_pkg::ORD_W'(bba_pkg::POOL_ORDER)) ? bba_pkg::ST_DONE
                                                                     : bba_pkg::ST_FBUD;
      end
      bba_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = bba_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bba_pkg::ST_CLEAR;
    endcase
  end

  // Table access per state
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = best_r;
    ram_wentry = '0;
    ram_raddr  = '0;
    unique case (state_r)
      bba_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_r;
        if (clr_idx_r == '0) begin
          ram_wentry = '{start: 1'b1, used: 1'b0,
                         order: bba_pkg::ORD_W'(bba_pkg::POOL_ORDER)};
        end
      end
      bba_pkg::ST_IDLE: begin
        ram_raddr = (in_chan.cmd == bba_pkg::CMD_FREE) ? in_chan.free_address : '0;
      end
      bba_pkg::ST_SCAN: begin
        ram_raddr = scan_nxt[bba_pkg::ADDR_W-1:0];
      end
      bba_pkg::ST_SPLIT: begin
        ram_we = 1'b1;
        if (split_more) begin
          // upper half becomes a free buddy
          ram_waddr  = best_r | (bba_pkg::ADDR_W'(1) << split_ord);
          ram_wentry = '{start: 1'b1, used: 1'b0, order: split_ord};
        end else begin
          ram_waddr  = best_r;
          ram_wentry = '{start: 1'b1, used: 1'b1, order: k_r};
        end
      end
      bba_pkg::ST_FCHK: begin
        if (free_ok) begin
          ram_we     = 1'b1;
          ram_waddr  = cur_a_r;
          ram_wentry = '{start: 1'b1, used: 1'b0, order: rd_entry.order};
        end
        ram_raddr = cur_a_r ^ (bba_pkg::ADDR_W'(1) << rd_entry.order);
      end
      bba_pkg::ST_FBUD: begin
        if (buddy_ok) begin
          // drop the upper half of the merged pair
          ram_we    = 1'b1;
          ram_waddr = high_addr;
        end
      end
      bba_pkg::ST_FLOW: begin
        ram_we     = 1'b1;
        ram_waddr  = low_addr;
        ram_wentry = '{start: 1'b1, used: 1'b0, order: ord_up};
        ram_raddr  = low_addr ^ (bba_pkg::ADDR_W'(1) << ord_up);
      end
      bba_pkg::ST_DONE: begin
        ram_we = 1'b0;
      end
      default: ram_we = 1'b0;
    endcase
  end

  // Working registers per state
  always_comb begin
    clr_idx_nxt   = clr_idx_r;
    scan_idx_nxt  = scan_idx_r;
    k_nxt         = k_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    best_ord_nxt  = best_ord_r;
    cur_a_nxt     = cur_a_r;
    cur_ord_nxt   = cur_ord_r;
    res_ok_nxt    = res_ok_r;
    res_start_nxt = res_start_r;
    res_end_nxt   = res_end_r;
    unique case (state_r)
      bba_pkg::ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + bba_pkg::ADDR_W'(1);
      end
      bba_pkg::ST_IDLE: begin
        if (in_accept) begin
          k_nxt         = in_k;
          found_nxt     = 1'b0;
          scan_idx_nxt  = '0;
          cur_a_nxt     = in_chan.free_address;
          res_ok_nxt    = 1'b0;
          res_start_nxt = '0;
          res_end_nxt   = '0;
        end
      end
      bba_pkg::ST_SCAN: begin
        if (scan_hit) begin
          found_nxt    = 1'b1;
          best_nxt     = scan_idx_r[bba_pkg::ADDR_W-1:0];
          best_ord_nxt = rd_entry.order;
        end
        scan_idx_nxt = scan_nxt;
      end
      bba_pkg::ST_SPLIT: begin
        if (split_more) begin
          best_ord_nxt = split_ord;
        end else begin
          res_ok_nxt    = 1'b1;
          res_start_nxt = best_r;
          res_end_nxt   = best_r + (bba_pkg::ADDR_W'(1) << k_r) - bba_pkg::ADDR_W'(1);
        end
      end
      bba_pkg::ST_FCHK: begin
        if (free_ok) begin
          res_ok_nxt    = 1'b1;
          res_start_nxt = cur_a_r;
          res_end_nxt   = cur_a_r + (bba_pkg::ADDR_W'(1) << rd_entry.order)
                          - bba_pkg::ADDR_W'(1);
          cur_ord_nxt   = rd_entry.order;
        end
      end
      bba_pkg::ST_FLOW: begin
        cur_a_nxt   = low_addr;
        cur_ord_nxt = ord_up;
      end
      default: begin
        found_nxt = found_r;
      end
    endcase
  end

  // Output word register
  assign out_valid_nxt = ((state_r == bba_pkg::ST_DONE) & out_free) |
                         (out_valid_r & ~out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bba_pkg::ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r  <= scan_idx_nxt;
    k_r         <= k_nxt;
    found_r     <= found_nxt;
    best_r      <= best_nxt;
    best_ord_r  <= best_ord_nxt;
    cur_a_r     <= cur_a_nxt;
    cur_ord_r   <= cur_ord_nxt;
    res_ok_r    <= res_ok_nxt;
    res_start_r <= res_start_nxt;
    res_end_r   <= res_end_nxt;
    if ((state_r == bba_pkg::ST_DONE) && out_free) begin
      out_ok_r    <= res_ok_r;
      out_start_r <= res_start_r;
      out_end_r   <= res_end_r;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.ok         = out_ok_r;
  assign out_chan.first_unit = out_start_r;
  assign out_chan.last_unit  = out_end_r;

endmodule
